>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk, quiet during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition is never seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

>>> rtl/hmac_pkg.sv
// ---------------------------------------------------------------------------
// hmac_pkg
// Operation codes, internal kinds and inter-stage types of the halfword MAC.
// ---------------------------------------------------------------------------
`default_nettype none

package hmac_pkg;

    // Operation codes as they arrive on the input channel
    localparam logic [2:0] OP_MLA      = 3'd0;
    localparam logic [2:0] OP_WIDE_ACC = 3'd1;
    localparam logic [2:0] OP_WIDE_MUL = 3'd2;
    localparam logic [2:0] OP_LONG_ACC = 3'd3;
    localparam logic [2:0] OP_MUL      = 3'd4;

    localparam int unsigned HALF_W = 16;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned PROD_W = WORD_W + HALF_W;

    // Decoded form of the operation, carried down the pipeline
    typedef enum logic [2:0] {
        KIND_ACC32,
        KIND_WIDE_ACC,
        KIND_WIDE_MUL,
        KIND_LONG,
        KIND_MUL
    } t_kind;

    // Side information that travels alongside the operands
    typedef struct packed {
        t_kind             kind;
        logic [WORD_W-1:0] acc_hi;
        logic [WORD_W-1:0] acc_lo;
    } t_side;

endpackage

`default_nettype wire

>>> rtl/hmac_select.sv
// ---------------------------------------------------------------------------
// hmac_select
// Stage one: decode the operation and pick and sign-extend the operands.
// ---------------------------------------------------------------------------
`default_nettype none

module hmac_select
    import hmac_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output      logic                     o_ready,
    input  wire logic [2:0]               i_operation,
    input  wire logic                     i_first_top,
    input  wire logic                     i_second_top,
    input  wire logic [WORD_W-1:0]        i_first_operand,
    input  wire logic [WORD_W-1:0]        i_second_operand,
    input  wire logic [WORD_W-1:0]        i_acc_lo,
    input  wire logic [WORD_W-1:0]        i_acc_hi,
    output      logic                     o_valid,
    input  wire logic                     i_ready,
    output      logic signed [WORD_W-1:0] o_mcand,
    output      logic signed [HALF_W-1:0] o_mplier,
    output      t_side                    o_side
);

    logic                     r_valid;
    logic signed [WORD_W-1:0] r_mcand;
    logic signed [HALF_W-1:0] r_mplier;
    t_side                    r_side;

    t_kind                    n_kind;
    logic [HALF_W-1:0]        n_first_half;
    logic signed [WORD_W-1:0] n_mcand;
    logic signed [HALF_W-1:0] n_mplier;

    // Decode; unused codes behave as the plain multiply
    always_comb begin
        case (i_operation)
            OP_MLA:      n_kind = KIND_ACC32;
            OP_WIDE_ACC: n_kind = KIND_WIDE_ACC;
            OP_WIDE_MUL: n_kind = KIND_WIDE_MUL;
            OP_LONG_ACC: n_kind = KIND_LONG;
            OP_MUL:      n_kind = KIND_MUL;
            default:     n_kind = KIND_MUL;
        endcase
    end

    // Pick halves; the wide forms take the whole first word
    always_comb begin
        n_first_half = i_first_top ? i_first_operand[WORD_W-1:HALF_W]
                                   : i_first_operand[HALF_W-1:0];
        n_mplier     = i_second_top ? i_second_operand[WORD_W-1:HALF_W]
                                    : i_second_operand[HALF_W-1:0];
        if (n_kind == KIND_WIDE_ACC || n_kind == KIND_WIDE_MUL) begin
            n_mcand = i_first_operand;
        end else begin
            n_mcand = {{(WORD_W-HALF_W){n_first_half[HALF_W-1]}}, n_first_half};
        end
    end

    assign o_ready = !r_valid || i_ready;

    // Advance the valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load payload when the stage moves
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mcand       <= n_mcand;
            r_mplier      <= n_mplier;
            r_side.kind   <= n_kind;
            r_side.acc_lo <= i_acc_lo;
            r_side.acc_hi <= i_acc_hi;
        end
    end

    assign o_valid  = r_valid;
    assign o_mcand  = r_mcand;
    assign o_mplier = r_mplier;
    assign o_side   = r_side;

endmodule

`default_nettype wire

>>> rtl/hmac_mult.sv
// ---------------------------------------------------------------------------
// hmac_mult
// Stage two: signed 32 by 16 multiply into a registered 48-bit product.
// ---------------------------------------------------------------------------
`default_nettype none

module hmac_mult
    import hmac_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output      logic                     o_ready,
    input  wire logic signed [WORD_W-1:0] i_mcand,
    input  wire logic signed [HALF_W-1:0] i_mplier,
    input  wire t_side                    i_side,
    output      logic                     o_valid,
    input  wire logic                     i_ready,
    output      logic signed [PROD_W-1:0] o_prod,
    output      t_side                    o_side
);

    logic                     r_valid;
    logic signed [PROD_W-1:0] r_prod;
    t_side                    r_side;
    logic signed [PROD_W-1:0] n_prod;

    // Full signed product, widened before the multiply
    assign n_prod  = PROD_W'(i_mcand) * PROD_W'(i_mplier);
    assign o_ready = !r_valid || i_ready;

    // Advance the valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Hold product and side data until taken
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prod <= n_prod;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;
    assign o_side  = r_side;

endmodule

`default_nettype wire

>>> rtl/hmac_accum.sv
// ---------------------------------------------------------------------------
// hmac_accum
// Stage three: accumulate, flag signed overflow and hold the result item.
// ---------------------------------------------------------------------------
`default_nettype none

module hmac_accum
    import hmac_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output      logic                     o_ready,
    input  wire logic signed [PROD_W-1:0] i_prod,
    input  wire t_side                    i_side,
    output      logic                     o_valid,
    input  wire logic                     i_ready,
    output      logic [WORD_W-1:0]        o_result_low,
    output      logic [WORD_W-1:0]        o_result_high,
    output      logic                     o_overflow
);

    logic                   r_valid;
    logic [WORD_W-1:0]      r_lo;
    logic [WORD_W-1:0]      r_hi;
    logic                   r_ovf;

    logic [WORD_W-1:0]      n_addend;
    logic [WORD_W-1:0]      n_sum32;
    logic                   n_ovf32;
    logic [2*WORD_W-1:0]    n_sum64;
    logic [WORD_W-1:0]      n_lo;
    logic [WORD_W-1:0]      n_hi;
    logic                   n_ovf;

    // Shared 32-bit add: product bits 47:16 for wide forms, else 31:0
    always_comb begin
        if (i_side.kind == KIND_WIDE_ACC || i_side.kind == KIND_WIDE_MUL) begin
            n_addend = i_prod[PROD_W-1:HALF_W];
        end else begin
            n_addend = i_prod[WORD_W-1:0];
        end
        n_sum32 = n_addend + i_side.acc_lo;
        n_ovf32 = ~(n_addend[WORD_W-1] ^ i_side.acc_lo[WORD_W-1])
                & (n_addend[WORD_W-1] ^ n_sum32[WORD_W-1]);
        n_sum64 = {{(2*WORD_W-PROD_W){i_prod[PROD_W-1]}}, i_prod}
                + {i_side.acc_hi, i_side.acc_lo};
    end

    // Select the result per form
    always_comb begin
        n_lo  = n_addend;
        n_hi  = '0;
        n_ovf = 1'b0;
        case (i_side.kind)
            KIND_ACC32, KIND_WIDE_ACC: begin
                n_lo  = n_sum32;
                n_ovf = n_ovf32;
            end
            KIND_LONG: begin
                n_lo = n_sum64[WORD_W-1:0];
                n_hi = n_sum64[2*WORD_W-1:WORD_W];
            end
            KIND_WIDE_MUL, KIND_MUL: begin
                n_lo = n_addend;
            end
            default: begin
                n_lo = n_addend;
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    // Advance the valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Hold the result item until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_ovf <= n_ovf;
        end
    end

    assign o_valid       = r_valid;
    assign o_result_low  = r_lo;
    assign o_result_high = r_hi;
    assign o_overflow    = r_ovf;

endmodule

`default_nettype wire

>>> rtl/halfword_multiply_accumulate_unit.sv
// ---------------------------------------------------------------------------
// halfword_multiply_accumulate_unit
// Signed halfword multiply group: 16x16 and 32x16 multiply with accumulate.
// ---------------------------------------------------------------------------
// Usage:
//   Instructions enter on the s_axis channel: tuser carries the operation
//   code and the two half selects, tdata the two source words and the
//   accumulator words. Results leave on the m_axis channel: tdata holds the
//   low and high result words, tuser the overflow flag of that result.
//   From input acceptance to m_axis_tvalid an item passes three register
//   stages in order: operand select, multiply, accumulate.
//   Throughput is one item per cycle while the receiver does not stall; the
//   single 32x16 multiplier stage then takes a new operand pair every cycle.
//   Each stage holds its item while the next one is full, so a receiver
//   stall backs up stage by stage; s_axis_tready drops only when all three
//   stages hold items and m_axis_tready is low. Nothing is lost or repeated.
//   A synchronous active-low reset empties the pipeline; items in flight
//   are dropped and no result appears until new items are accepted.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module halfword_multiply_accumulate_unit
    import hmac_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output      logic         s_axis_tready,
    // first_operand[31:0], second_operand[63:32], accumulate_low[95:64],
    // accumulate_high[127:96]
    input  wire logic [127:0] s_axis_tdata,
    // operation[2:0], first_top[3], second_top[4]
    input  wire logic [4:0]   s_axis_tuser,
    output      logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // result_low[31:0], result_high[63:32]
    output      logic [63:0]  m_axis_tdata,
    // overflow[0]
    output      logic [0:0]   m_axis_tuser
);

    logic                     w_v1;
    logic                     w_rdy2;
    logic signed [WORD_W-1:0] w_mcand;
    logic signed [HALF_W-1:0] w_mplier;
    t_side                    w_side1;

    logic                     w_v2;
    logic                     w_rdy3;
    logic signed [PROD_W-1:0] w_prod;
    t_side                    w_side2;

    logic [WORD_W-1:0]        w_res_lo;
    logic [WORD_W-1:0]        w_res_hi;
    logic                     w_ovf;

    // Operand select stage
    hmac_select u_select (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_operation      (s_axis_tuser[2:0]),
        .i_first_top      (s_axis_tuser[3]),
        .i_second_top     (s_axis_tuser[4]),
        .i_first_operand  (s_axis_tdata[31:0]),
        .i_second_operand (s_axis_tdata[63:32]),
        .i_acc_lo         (s_axis_tdata[95:64]),
        .i_acc_hi         (s_axis_tdata[127:96]),
        .o_valid          (w_v1),
        .i_ready          (w_rdy2),
        .o_mcand          (w_mcand),
        .o_mplier         (w_mplier),
        .o_side           (w_side1)
    );

    // Multiply stage
    hmac_mult u_mult (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_v1),
        .o_ready  (w_rdy2),
        .i_mcand  (w_mcand),
        .i_mplier (w_mplier),
        .i_side   (w_side1),
        .o_valid  (w_v2),
        .i_ready  (w_rdy3),
        .o_prod   (w_prod),
        .o_side   (w_side2)
    );

    // Accumulate stage and output register
    hmac_accum u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_v2),
        .o_ready       (w_rdy3),
        .i_prod        (w_prod),
        .i_side        (w_side2),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_result_low  (w_res_lo),
        .o_result_high (w_res_hi),
        .o_overflow    (w_ovf)
    );

    assign m_axis_tdata = {w_res_hi, w_res_lo};
    assign m_axis_tuser = w_ovf;

    // Input back-pressure only comes from a full pipeline behind a stalled output
    `ASSERT_CLK(a_stall_source, !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready),
        "input stalled without a stalled full pipeline")

    // Only the 32-bit accumulate forms may raise the overflow flag
    `ASSERT_CLK(a_ovf_kind, (w_v2 && w_rdy3 && w_side2.kind != KIND_ACC32
        && w_side2.kind != KIND_WIDE_ACC) |=> !m_axis_tuser[0],
        "overflow raised by a form without 32-bit accumulate")

    // Only the long accumulate form fills the high word
    `ASSERT_CLK(a_high_kind, (w_v2 && w_rdy3 && w_side2.kind != KIND_LONG)
        |=> (m_axis_tdata[63:32] == '0),
        "high result word set by a short form")

endmodule

`default_nettype wire

>>> tb/halfword_multiply_accumulate_unit_test.sv
// ---------------------------------------------------------------------------
// halfword_multiply_accumulate_unit_test
// Drives instruction items into the halfword MAC and checks every result.
// A scoreboard class predicts each result from the accepted instruction and
// compares it field by field with what leaves the block. Directed corner
// cases come first, then weighted random items under bursty input and a
// stalling receiver, including one long receiver hold-off and one drain.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module halfword_multiply_accumulate_unit_test;

    import hmac_pkg::*;

    // Codes outside the defined set; the block treats them as plain multiply
    localparam logic [2:0] OP_SPARE5 = 3'd5;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    localparam int unsigned RANDOM_ITEMS = 1930;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam longint unsigned TIMEOUT_NS = 20_000_000;

    typedef struct packed {
        logic [2:0]  op;
        logic        first_top;
        logic        second_top;
        logic [31:0] first_operand;
        logic [31:0] second_operand;
        logic [31:0] acc_lo;
        logic [31:0] acc_hi;
    } t_instr;

    typedef struct packed {
        logic [31:0] res_lo;
        logic [31:0] res_hi;
        logic        ovf;
    } t_outcome;

    // -----------------------------------------------------------------------
    // Scoreboard: predicts results and holds them until they leave the block
    // -----------------------------------------------------------------------
    class hmac_scoreboard;
        t_outcome    pending_q[$];
        int unsigned errors;
        int unsigned items_in;
        int unsigned results_out;
        int unsigned ovf_count;
        int unsigned op_count[8];

        function new();
            errors      = 0;
            items_in    = 0;
            results_out = 0;
            ovf_count   = 0;
            foreach (op_count[i]) op_count[i] = 0;
        endfunction

        // 32-bit add with signed overflow in the top bit
        function logic [32:0] add_word(logic [31:0] x, logic [31:0] y);
            logic [31:0] s;
            s = x + y;
            return {~(x[31] ^ y[31]) & (x[31] ^ s[31]), s};
        endfunction

        function t_outcome mac_result(t_instr it);
            logic signed [15:0] fh;
            logic signed [15:0] sh;
            logic signed [63:0] prod;
            logic [63:0]        sum64;
            logic [32:0]        sum33;
            t_outcome           r;
            r  = '0;
            fh = it.first_top  ? it.first_operand[31:16]  : it.first_operand[15:0];
            sh = it.second_top ? it.second_operand[31:16] : it.second_operand[15:0];
            case (it.op)
                OP_WIDE_ACC, OP_WIDE_MUL: begin
                    prod = $signed(it.first_operand) * sh;
                    if (it.op == OP_WIDE_ACC) begin
                        sum33    = add_word(prod[47:16], it.acc_lo);
                        r.res_lo = sum33[31:0];
                        r.ovf    = sum33[32];
                    end else begin
                        r.res_lo = prod[47:16];
                    end
                end
                OP_MLA: begin
                    prod     = fh * sh;
                    sum33    = add_word(prod[31:0], it.acc_lo);
                    r.res_lo = sum33[31:0];
                    r.ovf    = sum33[32];
                end
                OP_LONG_ACC: begin
                    prod     = fh * sh;
                    sum64    = prod + {it.acc_hi, it.acc_lo};
                    r.res_lo = sum64[31:0];
                    r.res_hi = sum64[63:32];
                end
                default: begin
                    prod     = fh * sh;
                    r.res_lo = prod[31:0];
                end
            endcase
            return r;
        endfunction

        function void note_item(t_instr it);
            pending_q.push_back(mac_result(it));
            items_in++;
            op_count[it.op]++;
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_result(t_outcome got);
            t_outcome want;
            results_out++;
            if (got.ovf) ovf_count++;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected result lo=%08h hi=%08h ovf=%0b",
                                 got.res_lo, got.res_hi, got.ovf));
                return;
            end
            want = pending_q.pop_front();
            if (got.res_lo !== want.res_lo)
                report($sformatf("result %0d low word %08h, predicted %08h",
                                 results_out, got.res_lo, want.res_lo));
            if (got.res_hi !== want.res_hi)
                report($sformatf("result %0d high word %08h, predicted %08h",
                                 results_out, got.res_hi, want.res_hi));
            if (got.ovf !== want.ovf)
                report($sformatf("result %0d overflow %0b, predicted %0b",
                                 results_out, got.ovf, want.ovf));
        endtask
    endclass

    // -----------------------------------------------------------------------
    // Signals and block under test
    // -----------------------------------------------------------------------
    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [4:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    hmac_scoreboard sb;
    bit             hold_req;
    bit             hold_active;
    int unsigned    burst_left;

    halfword_multiply_accumulate_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Guard against a hung run
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", sb.pending_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Monitors: note accepted items, check accepted results
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_instr it;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            it.op             = s_axis_tuser[2:0];
            it.first_top      = s_axis_tuser[3];
            it.second_top     = s_axis_tuser[4];
            it.first_operand  = s_axis_tdata[31:0];
            it.second_operand = s_axis_tdata[63:32];
            it.acc_lo         = s_axis_tdata[95:64];
            it.acc_hi         = s_axis_tdata[127:96];
            sb.note_item(it);
        end
    end

    always @(posedge i_clk) begin
        t_outcome got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.res_lo = m_axis_tdata[31:0];
            got.res_hi = m_axis_tdata[63:32];
            got.ovf    = m_axis_tuser[0];
            sb.check_result(got);
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: stall pattern in phases, long hold-off on request
    // -----------------------------------------------------------------------
    initial begin
        int unsigned stall_pct;
        int unsigned phase_len;
        m_axis_tready <= 1'b0;
        forever begin
            if (hold_req) begin
                hold_req    = 1'b0;
                hold_active = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_active = 1'b0;
            end else begin
                case ($urandom_range(0, 4))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    2:       stall_pct = 50;
                    3:       stall_pct = 85;
                    default: stall_pct = $urandom_range(0, 99);
                endcase
                phase_len = $urandom_range(10, 150);
                repeat (phase_len) begin
                    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
                    @(posedge i_clk);
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------
    function t_instr make_instr(logic [2:0] op, logic ft, logic st,
                                logic [31:0] a, logic [31:0] b,
                                logic [31:0] lo, logic [31:0] hi);
        t_instr it;
        it.op             = op;
        it.first_top      = ft;
        it.second_top     = st;
        it.first_operand  = a;
        it.second_operand = b;
        it.acc_lo         = lo;
        it.acc_hi         = hi;
        return it;
    endfunction

    // Bias words towards halves and words at the signed limits
    function logic [31:0] pick_word();
        logic [15:0] half_set [5];
        logic [31:0] word_set [4];
        half_set = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF};
        word_set = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        case ($urandom_range(0, 7))
            0:       return {half_set[$urandom_range(0, 4)], half_set[$urandom_range(0, 4)]};
            1:       return word_set[$urandom_range(0, 3)];
            2:       return {half_set[$urandom_range(0, 4)], 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function t_instr random_instr();
        logic [2:0] op;
        // Mostly defined codes, now and then a spare one
        op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 4));
        return make_instr(op, 1'($urandom), 1'($urandom), pick_word(), pick_word(),
                          pick_word(), pick_word());
    endfunction

    // Offer one item, wait for acceptance, then maybe open a gap
    task offer_item(t_instr it);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {it.second_top, it.first_top, it.op};
        s_axis_tdata  <= {it.acc_hi, it.acc_lo, it.second_operand, it.first_operand};
        do @(posedge i_clk); while (!s_axis_tready);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Drop valid and hold until every predicted result has left the block
    task drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin
        sb          = new();
        hold_req    = 1'b0;
        hold_active = 1'b0;
        burst_left  = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners: every code, product and accumulate extremes
        offer_item(make_instr(OP_MLA, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0));
        offer_item(make_instr(OP_MLA, 1'b0, 1'b0, 32'h0000_8000, 32'h0000_8000,
                              32'h7FFF_FFFF, 32'h1234_5678));
        offer_item(make_instr(OP_MLA, 1'b1, 1'b1, 32'h8000_1234, 32'h7FFF_0000,
                              32'h8000_0000, 32'h0));
        offer_item(make_instr(OP_MLA, 1'b1, 1'b0, 32'hFFFF_0000, 32'h0000_FFFF,
                              32'hFFFF_FFFF, 32'h0));
        offer_item(make_instr(OP_MLA, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF));
        offer_item(make_instr(OP_WIDE_ACC, 1'b0, 1'b0, 32'h7FFF_FFFF, 32'h0000_7FFF,
                              32'h7FFF_FFFF, 32'h0));
        offer_item(make_instr(OP_WIDE_ACC, 1'b1, 1'b1, 32'h8000_0000, 32'h8000_0000,
                              32'h4000_0000, 32'h0));
        offer_item(make_instr(OP_WIDE_ACC, 1'b0, 1'b0, 32'h8000_0000, 32'h0000_7FFF,
                              32'h8000_0000, 32'h0));
        offer_item(make_instr(OP_WIDE_ACC, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF));
        offer_item(make_instr(OP_WIDE_MUL, 1'b0, 1'b0, 32'h8000_0000, 32'h0000_8000,
                              32'hDEAD_BEEF, 32'h0));
        offer_item(make_instr(OP_WIDE_MUL, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_0001,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF));
        offer_item(make_instr(OP_WIDE_MUL, 1'b1, 1'b1, 32'h1234_5678, 32'hFFFF_0000,
                              32'hFFFF_FFFF, 32'h0));
        offer_item(make_instr(OP_LONG_ACC, 1'b0, 1'b0, 32'h0000_0001, 32'h0000_0001,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF));
        offer_item(make_instr(OP_LONG_ACC, 1'b0, 1'b0, 32'h0000_0001, 32'h0000_0001,
                              32'hFFFF_FFFF, 32'h0));
        offer_item(make_instr(OP_LONG_ACC, 1'b0, 1'b1, 32'h0000_8000, 32'h7FFF_0000,
                              32'h0, 32'h0));
        offer_item(make_instr(OP_LONG_ACC, 1'b1, 1'b1, 32'h8000_0000, 32'h8000_0000,
                              32'hFFFF_FFFF, 32'h7FFF_FFFF));
        offer_item(make_instr(OP_MUL, 1'b1, 1'b1, 32'h8000_0000, 32'h8000_FFFF,
                              32'h7FFF_FFFF, 32'hFFFF_FFFF));
        offer_item(make_instr(OP_MUL, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              32'h0, 32'h0));
        offer_item(make_instr(OP_SPARE5, 1'b0, 1'b1, 32'h0000_7FFF, 32'h8000_0000,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF));
        offer_item(make_instr(OP_SPARE6, 1'b1, 1'b0, 32'h8000_0000, 32'h0000_8000,
                              32'h7FFF_FFFF, 32'hFFFF_FFFF));
        offer_item(make_instr(OP_SPARE7, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 32'hFFFF_FFFF));

        // Random items, with a long receiver hold-off and a full drain inside
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 600) begin
                // Withdraw the item already taken while waiting for the hold-off
                s_axis_tvalid <= 1'b0;
                hold_req = 1'b1;
                while (!hold_active) @(posedge i_clk);
                // Keep offering back to back so the pipeline fills and stalls
                burst_left = 40;
            end
            if (n == 1200) drain();
            offer_item(random_instr());
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d items, %0d results, %0d with overflow set",
                 sb.items_in, sb.results_out, sb.ovf_count);
        $display("per code: %0d %0d %0d %0d %0d, spare codes %0d",
                 sb.op_count[0], sb.op_count[1], sb.op_count[2], sb.op_count[3],
                 sb.op_count[4], sb.op_count[5] + sb.op_count[6] + sb.op_count[7]);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> halfword_multiply_accumulate_unit.f
+incdir+rtl
rtl/hmac_pkg.sv
rtl/hmac_select.sv
rtl/hmac_mult.sv
rtl/hmac_accum.sv
rtl/halfword_multiply_accumulate_unit.sv
tb/halfword_multiply_accumulate_unit_test.sv
